// ===== rtl/bppm_pkg.sv =====
`default_nettype none
package bppm_pkg;

  localparam int NUM_CHANNELS    = 2;
  localparam int FRAME_SAMPLES   = 1024;
  localparam int TICKS_PER_FRAME = 40000;
  localparam int FADE_TICK_STEP  = 1;

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int AW     = $clog2(FRAME_SAMPLES);
  localparam int FP_W   = $clog2(FRAME_SAMPLES + 1);
  localparam int TICK_W = 16;
  localparam longint unsigned QMAX = (64'd65535 * FRAME_SAMPLES) / TICKS_PER_FRAME;
  localparam int POS_W  = $clog2(QMAX + 1);
  localparam int XW     = TICK_W + FP_W;
  localparam int RSH    = 32;
  localparam longint unsigned RECIP = (64'd1 << RSH) / TICKS_PER_FRAME;
  localparam int RW     = $clog2(RECIP + 1);

  localparam logic [1:0] ACT_EDGE  = 2'd0;
  localparam logic [1:0] ACT_CLOSE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [2:0] REG_TOTAL_VOLUME   = 3'd0;
  localparam logic [2:0] REG_PLAY_ENABLE    = 3'd1;
  localparam logic [2:0] REG_FADEOUT_ENABLE = 3'd2;
  localparam logic [2:0] REG_SILENCE_LEVEL  = 3'd3;
  localparam logic [2:0] REG_FADEOUT_PERIOD = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  channel;
    logic        level;
    logic [15:0] tick;
  } in_t;

  typedef struct packed {
    logic       valid_res;
    logic [7:0] sample;
    logic       frame_end;
  } out_t;

  typedef struct packed {
    logic [1:0]       action;
    logic             ch_ok;
    logic [2:0]       channel;
    logic             level;
    logic [POS_W-1:0] pos;
  } qent_t;

  typedef struct packed {
    logic [6:0]  total_volume;
    logic        play_enable;
    logic        fadeout_enable;
    logic [7:0]  silence_level;
    logic [15:0] fadeout_period;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/bppm_ram.sv =====
`default_nettype none
module bppm_ram #(
  parameter int W = 8,
  parameter int D = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/bppm_front.sv =====
`default_nettype none
module bppm_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire bppm_pkg::in_t   in_data,
  output logic                 q_push,
  output bppm_pkg::qent_t      q_wdata,
  input  wire logic            q_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_M1   = 2'd1;
  localparam logic [1:0] F_M2   = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]                          state_r;
  bppm_pkg::in_t                       item_r;
  logic [bppm_pkg::XW-1:0]             x_r;
  logic [bppm_pkg::XW+bppm_pkg::RW-1:0] p1_r;
  logic [bppm_pkg::POS_W-1:0]          q0_r;
  logic [bppm_pkg::XW:0]               m2_r;
  logic [bppm_pkg::POS_W-1:0]          q0;
  logic [bppm_pkg::XW:0]               rem;
  logic [bppm_pkg::POS_W-1:0]          pos;

  assign in_ready = (state_r == F_IDLE);

  // estimate from the reciprocal, then correct by one
  assign q0  = p1_r[bppm_pkg::RSH +: bppm_pkg::POS_W];
  assign rem = {1'b0, x_r} - m2_r;
  assign pos = (rem >= (bppm_pkg::XW+1)'(bppm_pkg::TICKS_PER_FRAME)) ? q0_r + 1'b1 : q0_r;

  assign q_push          = (state_r == F_PUSH) && !q_full;
  assign q_wdata.action  = item_r.action;
  assign q_wdata.ch_ok   = (32'(item_r.channel) < bppm_pkg::NUM_CHANNELS);
  assign q_wdata.channel = item_r.channel;
  assign q_wdata.level   = item_r.level;
  assign q_wdata.pos     = pos;

  // advance the tick-to-position sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: if (in_valid) state_r <= F_M1;
        F_M1:   state_r <= F_M2;
        F_M2:   state_r <= F_PUSH;
        F_PUSH: if (!q_full) state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
      x_r    <= bppm_pkg::XW'(in_data.tick * bppm_pkg::FP_W'(bppm_pkg::FRAME_SAMPLES));
    end
    p1_r <= x_r * bppm_pkg::RW'(bppm_pkg::RECIP);
    q0_r <= q0;
    m2_r <= (bppm_pkg::XW+1)'(q0 * 16'(bppm_pkg::TICKS_PER_FRAME));
  end

endmodule
`default_nettype wire

// ===== rtl/bppm_queue.sv =====
`default_nettype none
module bppm_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire bppm_pkg::qent_t wdata,
  output logic                 full,
  input  wire logic            pop,
  output logic                 valid,
  output bppm_pkg::qent_t      rdata
);

  bppm_pkg::qent_t mem_r [2];
  logic            wp_r;
  logic            rp_r;
  logic [1:0]      cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign rdata = mem_r[rp_r];

  // hold up to two classified items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule
`default_nettype wire

// ===== rtl/bppm_back.sv =====
`default_nettype none
module bppm_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bppm_pkg::cfg_t  cfg,
  input  wire logic            q_valid,
  input  wire bppm_pkg::qent_t q_rdata,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output bppm_pkg::out_t       out_data
);

  localparam int NCH  = bppm_pkg::NUM_CHANNELS;
  localparam int FR   = bppm_pkg::FRAME_SAMPLES;
  localparam int AW   = bppm_pkg::AW;
  localparam int FP_W = bppm_pkg::FP_W;
  localparam int CH_W = bppm_pkg::CH_W;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_FILL = 3'd1;
  localparam logic [2:0] B_EDGE = 3'd2;
  localparam logic [2:0] B_MIX  = 3'd3;
  localparam logic [2:0] B_RDW  = 3'd4;

  logic [2:0]       state_r;
  logic [FP_W-1:0]  fill_pos_r [NCH];
  logic [7:0]       held_r     [NCH];
  logic [7:0]       last_r     [NCH];
  logic [31:0]      fade_r     [NCH];
  logic [FP_W-1:0]  rp_r;
  logic             active_r;
  logic [CH_W-1:0]  fch_r;
  logic [FP_W-1:0]  idx_r;
  logic [FP_W-1:0]  end_r;
  logic             close_r;
  logic [7:0]       val_r;
  logic [bppm_pkg::POS_W-1:0] pos_r;
  logic [FP_W-1:0]  j_r;
  logic             mix_v_r;
  logic [AW-1:0]    mix_a_r;
  logic             out_valid_r;
  bppm_pkg::out_t   out_r;

  logic [7:0]       vol;
  logic [7:0]       val;
  logic [CH_W-1:0]  qch;
  logic [FP_W-1:0]  qend;
  logic             out_free;
  logic [31:0]      ft_add;
  logic [31:0]      ft_nxt;
  logic [7:0]       hv;
  logic [7:0]       gap_nxt;
  logic [CH_W-1:0]  fch_nxt;
  logic [FP_W-1:0]  rp_nxt;

  logic [NCH-1:0]   ch_we;
  logic [AW-1:0]    ch_wa;
  logic [7:0]       ch_wd;
  logic [7:0]       ch_rd [NCH];
  logic             o_we;
  logic [7:0]       o_wd;
  logic [7:0]       o_rd;
  logic [7:0]       mix_sum;

  // channel volume and the value of this edge
  always_comb begin
    vol = 8'(cfg.total_volume / NCH);
    if (vol == 8'd0 && cfg.total_volume != 7'd0) vol = 8'd1;
  end
  assign val  = q_rdata.level ? vol : 8'(8'd0 - vol);
  assign qch  = q_rdata.channel[CH_W-1:0];
  assign qend = (q_rdata.pos >= bppm_pkg::POS_W'(FR)) ? FP_W'(FR) : FP_W'(q_rdata.pos);
  assign out_free = !out_valid_r || out_ready;
  assign fch_nxt  = fch_r + 1'b1;
  assign rp_nxt   = rp_r + 1'b1;

  // one gap sample, with optional one-step decay toward zero
  always_comb begin
    hv      = held_r[fch_r];
    ft_add  = fade_r[fch_r] + 32'(bppm_pkg::FADE_TICK_STEP);
    ft_nxt  = ft_add;
    gap_nxt = hv;
    if (cfg.fadeout_enable && ft_add >= {16'd0, cfg.fadeout_period}) begin
      ft_nxt = ft_add - {16'd0, cfg.fadeout_period};
      if (hv >= 8'd1 && hv <= 8'h7F) begin
        gap_nxt = hv - 8'd1;
      end else if (hv >= 8'h80) begin
        gap_nxt = hv + 8'd1;
      end
    end
  end

  // pop only when the item can be carried out now
  always_comb begin
    q_pop = 1'b0;
    if (state_r == B_IDLE && q_valid) begin
      q_pop = (q_rdata.action == bppm_pkg::ACT_READ) ? out_free : 1'b1;
    end
  end

  // channel buffer write port
  always_comb begin
    ch_we = '0;
    ch_wa = idx_r[AW-1:0];
    ch_wd = gap_nxt;
    if (state_r == B_FILL && idx_r < end_r) begin
      ch_we[fch_r] = 1'b1;
    end else if (state_r == B_EDGE && pos_r < bppm_pkg::POS_W'(FR)) begin
      ch_we[fch_r] = 1'b1;
      ch_wa        = pos_r[AW-1:0];
      ch_wd        = val_r;
    end
  end

  // mix the channels with wrapping plus the silence offset
  always_comb begin
    mix_sum = cfg.silence_level;
    for (int i = 0; i < NCH; i++) begin
      mix_sum = mix_sum + ch_rd[i];
    end
  end
  assign o_we = mix_v_r;
  assign o_wd = mix_sum;

  for (genvar g = 0; g < NCH; g++) begin : g_ch
    bppm_ram #(.W(8), .D(FR)) u_ch_ram (
      .clk   (clk),
      .we    (ch_we[g]),
      .waddr (ch_wa),
      .wdata (ch_wd),
      .raddr (j_r[AW-1:0]),
      .rdata (ch_rd[g])
    );
  end

  bppm_ram #(.W(8), .D(FR)) u_out_ram (
    .clk   (clk),
    .we    (o_we),
    .waddr (mix_a_r),
    .wdata (o_wd),
    .raddr (rp_r[AW-1:0]),
    .rdata (o_rd)
  );

  // sequence edges, frame closes and reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      rp_r        <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      mix_v_r     <= 1'b0;
      for (int i = 0; i < NCH; i++) begin
        fill_pos_r[i] <= '0;
        held_r[i]     <= '0;
        last_r[i]     <= '0;
        fade_r[i]     <= '0;
      end
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (q_valid && q_pop) begin
            unique case (q_rdata.action)
              bppm_pkg::ACT_EDGE: begin
                if (cfg.play_enable && q_rdata.ch_ok && last_r[qch] != val) begin
                  fch_r   <= qch;
                  idx_r   <= fill_pos_r[qch];
                  end_r   <= qend;
                  val_r   <= val;
                  pos_r   <= q_rdata.pos;
                  close_r <= 1'b0;
                  state_r <= B_FILL;
                end
              end
              bppm_pkg::ACT_CLOSE: begin
                if (cfg.play_enable) begin
                  fch_r   <= '0;
                  idx_r   <= fill_pos_r[0];
                  end_r   <= FP_W'(FR);
                  close_r <= 1'b1;
                  state_r <= B_FILL;
                end
              end
              bppm_pkg::ACT_READ: begin
                if (!active_r || rp_r >= FP_W'(FR)) begin
                  active_r    <= 1'b0;
                  out_valid_r <= 1'b1;
                  out_r       <= '0;
                end else begin
                  state_r <= B_RDW;
                end
              end
              default: ;
            endcase
          end
        end
        B_FILL: begin
          if (idx_r < end_r) begin
            idx_r         <= idx_r + 1'b1;
            held_r[fch_r] <= gap_nxt;
            if (cfg.fadeout_enable) fade_r[fch_r] <= ft_nxt;
          end else if (close_r) begin
            fill_pos_r[fch_r] <= '0;
            if (32'(fch_r) == NCH - 1) begin
              j_r     <= '0;
              state_r <= B_MIX;
            end else begin
              fch_r <= fch_nxt;
              idx_r <= fill_pos_r[fch_nxt];
            end
          end else begin
            state_r <= B_EDGE;
          end
        end
        B_EDGE: begin
          if (pos_r < bppm_pkg::POS_W'(FR)) begin
            fill_pos_r[fch_r] <= FP_W'(pos_r + 1'b1);
          end else begin
            fill_pos_r[fch_r] <= FP_W'(FR);
          end
          held_r[fch_r] <= val_r;
          last_r[fch_r] <= val_r;
          state_r       <= B_IDLE;
        end
        B_MIX: begin
          mix_v_r <= (j_r < FP_W'(FR));
          mix_a_r <= j_r[AW-1:0];
          if (j_r < FP_W'(FR)) begin
            j_r <= j_r + 1'b1;
          end else if (!mix_v_r) begin
            rp_r     <= '0;
            active_r <= 1'b1;
            state_r  <= B_IDLE;
          end
        end
        B_RDW: begin
          out_valid_r     <= 1'b1;
          out_r.valid_res <= 1'b1;
          out_r.sample    <= o_rd;
          if (rp_nxt >= FP_W'(FR)) begin
            active_r        <= 1'b0;
            rp_r            <= '0;
            out_r.frame_end <= 1'b1;
          end else begin
            rp_r            <= rp_nxt;
            out_r.frame_end <= 1'b0;
          end
          state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/beeper_pcm_renderer_mixer_core.sv =====
`default_nettype none
// Beeper renderer and mixer. Edge items map their tick to a frame position and
// fill their own channel's buffer up to it; a close item fills all channels to the
// frame end and mixes them into the output frame; read items return its bytes.
// The front maps each tick by reciprocal multiply and takes no new item until
// the last one is pushed to the queue; the back writes one sample per cycle
// through the RAM port of the channel being filled. Buffers need no clearing
// after reset: every entry is written before it is read.
module beeper_pcm_renderer_mixer_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire bppm_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output bppm_pkg::out_t       out_data,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_addr,
  input  wire logic [15:0]     cfg_wdata
);

  bppm_pkg::cfg_t  cfg_r;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  bppm_pkg::qent_t q_wdata;
  bppm_pkg::qent_t q_rdata;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total_volume   <= 7'd64;
      cfg_r.play_enable    <= 1'b1;
      cfg_r.fadeout_enable <= 1'b0;
      cfg_r.silence_level  <= 8'd128;
      cfg_r.fadeout_period <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bppm_pkg::REG_TOTAL_VOLUME:   cfg_r.total_volume   <= cfg_wdata[6:0];
        bppm_pkg::REG_PLAY_ENABLE:    cfg_r.play_enable    <= cfg_wdata[0];
        bppm_pkg::REG_FADEOUT_ENABLE: cfg_r.fadeout_enable <= cfg_wdata[0];
        bppm_pkg::REG_SILENCE_LEVEL:  cfg_r.silence_level  <= cfg_wdata[7:0];
        bppm_pkg::REG_FADEOUT_PERIOD: cfg_r.fadeout_period <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bppm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  bppm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  bppm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/bppm_checker.sv =====
`default_nettype none
module bppm_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire bppm_pkg::out_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // an empty read carries no byte
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |-> out_data.sample == 8'd0 && !out_data.frame_end)
    else $error("empty read carries data");

  // frame end only on a real byte
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.valid_res)
    else $error("frame end without byte");

  // the front is busy right after it takes an item
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("front took items back to back");

endmodule

bind beeper_pcm_renderer_mixer_core bppm_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
